/* src/cnavg_pkg.sv */
// cnavg_pkg: shared types and constants for the cell-to-node averaging block
// no dependencies; imported by every module under src but cnavg_fifo

package cnavg_pkg;

    localparam int COORD_W   = 11;   // node coordinate width
    localparam int CFG_W     = 11;   // widest configuration register
    localparam int CFG_IDX_W = 2;    // configuration register index width
    localparam int MAX_ROWS  = 1024; // largest usable row count
    localparam int ROW_W     = 10;   // row counter width, holds MAX_ROWS-1
    localparam int SLOT_N    = 8;    // most nodes one cell can complete

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS     = 2'd0,
        REG_ROWS     = 2'd1,
        REG_PERIODIC = 2'd2
    } cfg_reg_t;

    // emission slots of one cell, in output order
    typedef enum logic [2:0] {
        SLOT_ROW    = 3'd0,  // node (x, y)
        SLOT_SIDE_L = 3'd1,  // node (0, y), periodic side
        SLOT_SIDE_R = 3'd2,  // node (cols, y)
        SLOT_LOW_L  = 3'd3,  // node (0, 0), periodic corner
        SLOT_LOW_R  = 3'd4,  // node (cols, 0), periodic corner
        SLOT_TOP    = 3'd5,  // node (x, rows)
        SLOT_TOP_L  = 3'd6,  // node (0, rows), periodic corner
        SLOT_TOP_R  = 3'd7   // node (cols, rows)
    } slot_t;

    // control part of one queued cell request
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] nc;
        logic [COORD_W-1:0] nr;
        logic               per;
        logic [SLOT_N-1:0]  mask;
    } node_ctl_t;

endpackage

/* src/cnavg_fifo.sv */
// cnavg_fifo: small register queue between the front and back parts
// depends on nothing but its parameters

module cnavg_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic [$clog2(DEPTH):0]     count
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (!wr_en && rd_en) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

/* src/cnavg_front.sv */
// cnavg_front: configuration registers, raster counters, row store and
// per-cell classification into queued requests; uses cnavg_pkg

module cnavg_front
    import cnavg_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 32,
    parameter int FIFO_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_BITS-1:0]  s_cell_value,
    input  logic [$clog2(FIFO_DEPTH):0]   fifo_count,
    output logic                          push,
    output node_ctl_t                     push_ctl,
    output logic signed [VALUE_BITS-1:0]  push_row_val,
    output logic signed [VALUE_BITS-1:0]  push_side_val,
    output logic signed [VALUE_BITS-1:0]  push_top_val,
    output logic signed [VALUE_BITS-1:0]  push_cur,
    output logic signed [VALUE_BITS+1:0]  push_lo1,
    output logic signed [VALUE_BITS+1:0]  push_lo2,
    output logic signed [VALUE_BITS+1:0]  push_hi1,
    output logic signed [VALUE_BITS+1:0]  push_hi2
);

    localparam int AW  = $clog2(MAX_COLS);
    localparam int VW  = VALUE_BITS;
    localparam int SW  = VALUE_BITS + 2;
    localparam int CNW = $clog2(FIFO_DEPTH) + 1;

    function automatic logic signed [SW-1:0] sx(input logic signed [VW-1:0] v);
        return {{2{v[VW-1]}}, v};
    endfunction

    function automatic logic signed [VW-1:0] mean2(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] r;
        s = sx(a) + sx(b);
        r = s >>> 1;
        return r[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] mean4(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b,
                                                  input logic signed [VW-1:0] c,
                                                  input logic signed [VW-1:0] d);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] r;
        s = (sx(a) + sx(b)) + (sx(c) + sx(d));
        r = s >>> 2;
        return r[VW-1:0];
    endfunction

    // one-step extrapolation a - floor((b - a) / 2)
    function automatic logic signed [SW-1:0] extrap(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
        logic signed [SW-1:0] d;
        d = sx(b) - sx(a);
        return sx(a) - (d >>> 1);
    endfunction

    // configuration
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    logic             per_reg;
    logic             cfg_hit;
    logic [AW:0]      nc;
    logic [ROW_W:0]   nr;

    // raster position of the next cell
    logic [AW-1:0]    col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic             last_col;
    logic             last_row;
    logic             accept;

    // row store, read-first
    logic [VW-1:0]    row_mem [MAX_COLS];
    logic [VW-1:0]    above_reg;

    // classify stage
    logic                 s1_valid_reg;
    logic signed [VW-1:0] s1_cur_reg;
    logic [AW-1:0]        s1_x_reg;
    logic [ROW_W-1:0]     s1_y_reg;
    logic                 s1_lc_reg;
    logic                 s1_lr_reg;

    logic signed [VW-1:0] left_reg;
    logic signed [VW-1:0] ul_reg;
    logic signed [VW-1:0] rf_reg;
    logic signed [VW-1:0] pf_reg;
    logic signed [VW-1:0] bre0_reg;
    logic signed [VW-1:0] bre1_reg;

    logic signed [VW-1:0] above;
    logic signed [VW-1:0] rf_eff;
    logic signed [VW-1:0] pf_eff;
    logic signed [VW-1:0] m2_left;
    logic                 xz;
    logic                 y0;
    logic                 y1;
    logic [SLOT_N-1:0]    mask;

    always_comb begin
        cfg_hit = cfg_wr_en && (cfg_index == REG_COLS || cfg_index == REG_ROWS ||
                                cfg_index == REG_PERIODIC);
        if (cols_reg < CFG_W'(2)) begin
            nc = (AW+1)'(2);
        end else if (int'(cols_reg) > MAX_COLS) begin
            nc = (AW+1)'(MAX_COLS);
        end else begin
            nc = (AW+1)'(cols_reg);
        end
        if (rows_reg < CFG_W'(2)) begin
            nr = (ROW_W+1)'(2);
        end else if (int'(rows_reg) > MAX_ROWS) begin
            nr = (ROW_W+1)'(MAX_ROWS);
        end else begin
            nr = (ROW_W+1)'(rows_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= CFG_W'(2);
            rows_reg <= CFG_W'(2);
            per_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COLS:     cols_reg <= cfg_data;
                REG_ROWS:     rows_reg <= cfg_data;
                REG_PERIODIC: per_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // room for this request and the one in the classify stage
    assign s_ready  = (CNW'(fifo_count) + CNW'(s1_valid_reg)) < CNW'(FIFO_DEPTH);
    assign accept   = s_valid && s_ready;
    assign last_col = ({1'b0, col_cnt_reg} == nc - (AW+1)'(1));
    assign last_row = ({1'b0, row_cnt_reg} == nr - (ROW_W+1)'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (cfg_hit) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            if (last_col) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end else begin
                col_cnt_reg <= col_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            above_reg            <= row_mem[col_cnt_reg];
            row_mem[col_cnt_reg] <= s_cell_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cur_reg <= s_cell_value;
            s1_x_reg   <= col_cnt_reg;
            s1_y_reg   <= row_cnt_reg;
            s1_lc_reg  <= last_col;
            s1_lr_reg  <= last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_comb begin
        above   = above_reg;
        xz      = (s1_x_reg == '0);
        y0      = (s1_y_reg == '0);
        y1      = (s1_y_reg == ROW_W'(1));
        rf_eff  = xz ? s1_cur_reg : rf_reg;
        pf_eff  = xz ? rf_reg : pf_reg;
        m2_left = mean2(left_reg, s1_cur_reg);

        mask              = '0;
        mask[SLOT_ROW]    = !xz || !per_reg;
        mask[SLOT_SIDE_L] = s1_lc_reg && per_reg && !y0;
        mask[SLOT_SIDE_R] = s1_lc_reg && (!per_reg || !y0);
        mask[SLOT_LOW_L]  = s1_lc_reg && per_reg && y1;
        mask[SLOT_LOW_R]  = s1_lc_reg && per_reg && y1;
        mask[SLOT_TOP]    = s1_lr_reg && (!xz || !per_reg);
        mask[SLOT_TOP_L]  = s1_lr_reg && s1_lc_reg && per_reg;
        mask[SLOT_TOP_R]  = s1_lr_reg && s1_lc_reg;

        if (y0) begin
            push_row_val = xz ? s1_cur_reg : m2_left;
        end else begin
            push_row_val = xz ? mean2(s1_cur_reg, above)
                              : mean4(left_reg, s1_cur_reg, ul_reg, above);
        end
        if (per_reg) begin
            push_side_val = mean4(s1_cur_reg, rf_eff, above, pf_eff);
        end else begin
            push_side_val = y0 ? s1_cur_reg : mean2(s1_cur_reg, above);
        end
        push_top_val = xz ? s1_cur_reg : m2_left;
        push_cur     = s1_cur_reg;
        push_lo1     = extrap(bre1_reg, s1_cur_reg);
        push_lo2     = extrap(bre0_reg, rf_eff);
        push_hi1     = extrap(s1_cur_reg, above);
        push_hi2     = extrap(rf_eff, pf_eff);

        push_ctl.x    = COORD_W'(s1_x_reg);
        push_ctl.y    = COORD_W'(s1_y_reg);
        push_ctl.nc   = COORD_W'(nc);
        push_ctl.nr   = COORD_W'(nr);
        push_ctl.per  = per_reg;
        push_ctl.mask = mask;

        // a cell that completes no node is dropped here
        push = s1_valid_reg && (mask != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            ul_reg   <= '0;
            rf_reg   <= '0;
            pf_reg   <= '0;
            bre0_reg <= '0;
            bre1_reg <= '0;
        end else if (s1_valid_reg) begin
            left_reg <= s1_cur_reg;
            ul_reg   <= above;
            if (xz) begin
                pf_reg <= rf_reg;
                rf_reg <= s1_cur_reg;
            end
            if (y0 && s1_lc_reg) begin
                bre0_reg <= rf_eff;
                bre1_reg <= s1_cur_reg;
            end
        end
    end

endmodule

/* src/cnavg_back.sv */
// cnavg_back: walks the slot mask of each queued request and drives one
// node per cycle, while m_ready allows, through the output register; uses cnavg_pkg

module cnavg_back
    import cnavg_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  node_ctl_t                     q_ctl,
    input  logic signed [VALUE_BITS-1:0]  q_row_val,
    input  logic signed [VALUE_BITS-1:0]  q_side_val,
    input  logic signed [VALUE_BITS-1:0]  q_top_val,
    input  logic signed [VALUE_BITS-1:0]  q_cur,
    input  logic signed [VALUE_BITS+1:0]  q_lo1,
    input  logic signed [VALUE_BITS+1:0]  q_lo2,
    input  logic signed [VALUE_BITS+1:0]  q_hi1,
    input  logic signed [VALUE_BITS+1:0]  q_hi2,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COORD_W-1:0]            m_node_col,
    output logic [COORD_W-1:0]            m_node_row,
    output logic signed [VALUE_BITS-1:0]  m_node_value,
    output logic                          m_run_end
);

    localparam int VW = VALUE_BITS;
    localparam int SW = VALUE_BITS + 2;

    node_ctl_t            ctl_reg;
    logic [SLOT_N-1:0]    mask_reg;
    logic [SLOT_N-1:0]    mask_next;
    logic [SLOT_N-1:0]    mask_after;
    logic signed [VW-1:0] row_val_reg;
    logic signed [VW-1:0] side_val_reg;
    logic signed [VW-1:0] top_val_reg;
    logic signed [VW-1:0] cur_reg;
    logic signed [SW-1:0] lo1_reg;
    logic signed [SW-1:0] lo2_reg;
    logic signed [SW-1:0] hi1_reg;
    logic signed [SW-1:0] hi2_reg;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [COORD_W-1:0]   m_col_reg;
    logic [COORD_W-1:0]   m_row_reg;
    logic signed [VW-1:0] m_value_reg;
    logic                 m_end_reg;

    slot_t                sel;
    logic                 out_free;
    logic                 emit;
    logic                 load;
    logic                 low_pick;
    logic signed [SW-1:0] ca;
    logic signed [SW-1:0] cb;
    logic signed [SW-1:0] csum;
    logic [COORD_W-1:0]   col_sel;
    logic [COORD_W-1:0]   row_sel;
    logic signed [VW-1:0] val_sel;

    // lowest pending slot goes first
    always_comb begin
        sel = SLOT_TOP_R;
        for (int i = SLOT_N - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = slot_t'(3'(i));
            end
        end
    end

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        emit       = out_free && (mask_reg != '0);
        mask_after = emit ? (mask_reg & ~(SLOT_N'(1) << sel)) : mask_reg;
        load       = (mask_after == '0) && !q_empty;
        q_pop      = load;
        mask_next  = load ? q_ctl.mask : mask_after;

        low_pick = (sel == SLOT_LOW_L) || (sel == SLOT_LOW_R);
        ca       = low_pick ? lo1_reg : hi1_reg;
        cb       = low_pick ? lo2_reg : hi2_reg;
        csum     = (ca + cb) >>> 1;

        unique case (sel) inside
            SLOT_ROW: begin
                col_sel = ctl_reg.x;
                row_sel = ctl_reg.y;
                val_sel = row_val_reg;
            end
            SLOT_SIDE_L: begin
                col_sel = '0;
                row_sel = ctl_reg.y;
                val_sel = side_val_reg;
            end
            SLOT_SIDE_R: begin
                col_sel = ctl_reg.nc;
                row_sel = ctl_reg.y;
                val_sel = side_val_reg;
            end
            SLOT_LOW_L, SLOT_LOW_R: begin
                col_sel = (sel == SLOT_LOW_L) ? '0 : ctl_reg.nc;
                row_sel = '0;
                val_sel = csum[VW-1:0];
            end
            SLOT_TOP: begin
                col_sel = ctl_reg.x;
                row_sel = ctl_reg.nr;
                val_sel = top_val_reg;
            end
            SLOT_TOP_L, SLOT_TOP_R: begin
                col_sel = (sel == SLOT_TOP_L) ? '0 : ctl_reg.nc;
                row_sel = ctl_reg.nr;
                val_sel = ctl_reg.per ? csum[VW-1:0] : cur_reg;
            end
            default: begin
                col_sel = ctl_reg.x;
                row_sel = ctl_reg.y;
                val_sel = row_val_reg;
            end
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ctl_reg      <= q_ctl;
            row_val_reg  <= q_row_val;
            side_val_reg <= q_side_val;
            top_val_reg  <= q_top_val;
            cur_reg      <= q_cur;
            lo1_reg      <= q_lo1;
            lo2_reg      <= q_lo2;
            hi1_reg      <= q_hi1;
            hi2_reg      <= q_hi2;
        end
        if (emit) begin
            m_col_reg   <= col_sel;
            m_row_reg   <= row_sel;
            m_value_reg <= val_sel;
            m_end_reg   <= (mask_after == '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_node_col   = m_col_reg;
    assign m_node_row   = m_row_reg;
    assign m_node_value = m_value_reg;
    assign m_run_end    = m_end_reg;

endmodule

/* src/cell_to_node_average.sv */
// cell_to_node_average: top level, cell-centre to grid-node interpolation
// path: classify stage, queue, slot walker registers, then the output register
// throughput: one cell per cycle while cells complete one node at most and m_ready;
//   a row-end cell completes up to 8 nodes, one per cycle while m_ready is high
// reset: aresetn synchronous active low; cols=2, rows=2, periodic_mode=0, counters
//   at cell (0,0); the row store is not cleared, each entry is written a row before use

module cell_to_node_average
    import cnavg_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes, only while idle: the user's duty, not enforced by the block
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    // cell stream in raster order
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_BITS-1:0]  s_cell_value,
    // node stream
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COORD_W-1:0]            m_node_col,
    output logic [COORD_W-1:0]            m_node_row,
    output logic signed [VALUE_BITS-1:0]  m_node_value,
    output logic                          m_run_end
);

    localparam int VW         = VALUE_BITS;
    localparam int SW         = VALUE_BITS + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int CTL_W      = $bits(node_ctl_t);
    localparam int DW         = CTL_W + 4 * VW + 4 * SW;

    // front to queue
    logic                        push;
    node_ctl_t                   push_ctl;
    logic signed [VW-1:0]        push_row_val;
    logic signed [VW-1:0]        push_side_val;
    logic signed [VW-1:0]        push_top_val;
    logic signed [VW-1:0]        push_cur;
    logic signed [SW-1:0]        push_lo1;
    logic signed [SW-1:0]        push_lo2;
    logic signed [SW-1:0]        push_hi1;
    logic signed [SW-1:0]        push_hi2;
    logic [$clog2(FIFO_DEPTH):0] fifo_count;

    // queue to back
    logic [DW-1:0]               wr_data;
    logic [DW-1:0]               rd_data;
    logic                        q_empty;
    logic                        q_pop;
    node_ctl_t                   q_ctl;
    logic signed [VW-1:0]        q_row_val;
    logic signed [VW-1:0]        q_side_val;
    logic signed [VW-1:0]        q_top_val;
    logic signed [VW-1:0]        q_cur;
    logic signed [SW-1:0]        q_lo1;
    logic signed [SW-1:0]        q_lo2;
    logic signed [SW-1:0]        q_hi1;
    logic signed [SW-1:0]        q_hi2;

    // front: counters, row store read, neighbor tracking, slot mask and the
    // per-request means; the row store read is registered together with the classify stage
    cnavg_front #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_value  (s_cell_value),
        .fifo_count    (fifo_count),
        .push          (push),
        .push_ctl      (push_ctl),
        .push_row_val  (push_row_val),
        .push_side_val (push_side_val),
        .push_top_val  (push_top_val),
        .push_cur      (push_cur),
        .push_lo1      (push_lo1),
        .push_lo2      (push_lo2),
        .push_hi1      (push_hi1),
        .push_hi2      (push_hi2)
    );

    // one request per cell that completes at least one node
    assign wr_data = {push_ctl, push_row_val, push_side_val, push_top_val, push_cur,
                      push_lo1, push_lo2, push_hi1, push_hi2};

    // short queue that holds requests while the back side works through a row-end burst
    cnavg_fifo #(
        .WIDTH (DW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (wr_data),
        .rd_en   (q_pop),
        .rd_data (rd_data),
        .empty   (q_empty),
        .count   (fifo_count)
    );

    assign {q_ctl, q_row_val, q_side_val, q_top_val, q_cur,
            q_lo1, q_lo2, q_hi1, q_hi2} = rd_data;

    // back: one node per cycle while m_ready allows, periodic corners finished with a single add
    cnavg_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_ctl        (q_ctl),
        .q_row_val    (q_row_val),
        .q_side_val   (q_side_val),
        .q_top_val    (q_top_val),
        .q_cur        (q_cur),
        .q_lo1        (q_lo1),
        .q_lo2        (q_lo2),
        .q_hi1        (q_hi1),
        .q_hi2        (q_hi2),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_node_col   (m_node_col),
        .m_node_row   (m_node_row),
        .m_node_value (m_node_value),
        .m_run_end    (m_run_end)
    );

endmodule

/* dv/node_checker.sv */
// node_checker: predicts the node stream of cell_to_node_average and checks every node
// depends on cnavg_pkg for coordinate widths, register indexes and the slot count
`timescale 1ns / 100ps

module node_checker
    import cnavg_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_cell_value,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [COORD_W-1:0]           m_node_col,
    input  logic [COORD_W-1:0]           m_node_row,
    input  logic signed [VALUE_BITS-1:0] m_node_value,
    input  logic                         m_run_end,
    output int                           mismatch_count,
    output int                           nodes_pending
);

    typedef struct packed {
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    row;
        logic [VALUE_BITS-1:0] value;
        logic                  run_end;
    } grid_node_t;

    // grid setup as last written
    logic [CFG_W-1:0] grid_cols;
    logic [CFG_W-1:0] grid_rows;
    logic             wrap_sides;

    // cells kept for later nodes, held sign-extended
    longint prev_row [MAX_COLS];
    longint left_val;
    longint upper_left_val;
    longint row_head;
    longint prev_row_head;
    longint base_first;
    longint base_last;
    int     col_pos;
    int     row_pos;

    grid_node_t expected_nodes [$];
    grid_node_t burst [SLOT_N];
    int         burst_len;
    grid_node_t want;

    function automatic int fit(input int d, input int top);
        return (d < 2) ? 2 : ((d > top) ? top : d);
    endfunction

    function automatic logic [VALUE_BITS-1:0] mean_of_two(input longint a, input longint b);
        return VALUE_BITS'((a + b) >>> 1);
    endfunction

    function automatic logic [VALUE_BITS-1:0] mean_of_four(input longint a, input longint b,
                                                         input longint c, input longint d);
        return VALUE_BITS'((a + b + c + d) >>> 2);
    endfunction

    // each boundary column stepped one row outward, then averaged; wraps, no saturation
    function automatic logic [VALUE_BITS-1:0] extrapolated_corner(input longint a1,
            input longint b1, input longint a2, input longint b2);
        longint t1;
        longint t2;
        t1 = a1 - ((b1 - a1) >>> 1);
        t2 = a2 - ((b2 - a2) >>> 1);
        return VALUE_BITS'((t1 + t2) >>> 1);
    endfunction

    task automatic stage_node(input int c, input int r, input logic [VALUE_BITS-1:0] v);
        burst[burst_len] = '{col: COORD_W'(c), row: COORD_W'(r), value: v, run_end: 1'b0};
        burst_len++;
    endtask

    task automatic clear_grid();
        grid_cols      = CFG_W'(2);
        grid_rows      = CFG_W'(2);
        wrap_sides     = 1'b0;
        left_val       = 0;
        upper_left_val = 0;
        row_head       = 0;
        prev_row_head  = 0;
        base_first     = 0;
        base_last      = 0;
        col_pos        = 0;
        row_pos        = 0;
        foreach (prev_row[i]) prev_row[i] = 0;
        expected_nodes.delete();
    endtask

    task automatic predict_nodes(input logic signed [VALUE_BITS-1:0] raw);
        longint                cur;
        longint                above;
        logic [VALUE_BITS-1:0] side;
        int                    nc;
        int                    nr;
        int                    x;
        int                    y;
        bit                    last_c;
        bit                    last_r;
        cur = raw;
        nc  = fit(int'(grid_cols), MAX_COLS);
        nr  = fit(int'(grid_rows), MAX_ROWS);
        if (col_pos >= nc || row_pos >= nr) begin
            col_pos = 0;
            row_pos = 0;
        end
        x         = col_pos;
        y         = row_pos;
        last_c    = (x == nc - 1);
        last_r    = (y == nr - 1);
        above     = prev_row[x];
        burst_len = 0;
        if (x == 0) begin
            prev_row_head = row_head;
            row_head      = cur;
        end

        // nodes below this cell
        if (y == 0) begin
            if (x == 0) begin
                if (!wrap_sides) stage_node(0, 0, VALUE_BITS'(cur));
            end else begin
                stage_node(x, 0, mean_of_two(left_val, cur));
            end
            if (last_c) begin
                base_first = row_head;
                base_last  = cur;
                if (!wrap_sides) stage_node(nc, 0, VALUE_BITS'(cur));
            end
        end else begin
            if (x == 0) begin
                if (!wrap_sides) stage_node(0, y, mean_of_two(cur, above));
            end else begin
                stage_node(x, y, mean_of_four(left_val, cur, upper_left_val, above));
            end
            if (last_c) begin
                if (!wrap_sides) begin
                    stage_node(nc, y, mean_of_two(cur, above));
                end else begin
                    side = mean_of_four(cur, row_head, above, prev_row_head);
                    stage_node(0, y, side);
                    stage_node(nc, y, side);
                    if (y == 1) begin
                        side = extrapolated_corner(base_last, cur, base_first, row_head);
                        stage_node(0, 0, side);
                        stage_node(nc, 0, side);
                    end
                end
            end
        end

        // nodes above the last row
        if (last_r) begin
            if (x == 0) begin
                if (!wrap_sides) stage_node(0, nr, VALUE_BITS'(cur));
            end else begin
                stage_node(x, nr, mean_of_two(left_val, cur));
            end
            if (last_c) begin
                if (!wrap_sides) begin
                    stage_node(nc, nr, VALUE_BITS'(cur));
                end else begin
                    side = extrapolated_corner(cur, above, row_head, prev_row_head);
                    stage_node(0, nr, side);
                    stage_node(nc, nr, side);
                end
            end
        end

        upper_left_val = above;
        prev_row[x]    = cur;
        left_val       = cur;
        if (last_c) begin
            col_pos = 0;
            row_pos = last_r ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end

        for (int i = 0; i < burst_len; i++) begin
            if (i == burst_len - 1) burst[i].run_end = 1'b1;
            expected_nodes.push_back(burst[i]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_grid();
            mismatch_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_COLS: begin
                        grid_cols = cfg_data;
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    REG_ROWS: begin
                        grid_rows = cfg_data;
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    REG_PERIODIC: begin
                        wrap_sides = cfg_data[0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_nodes(s_cell_value);
            if (m_valid && m_ready) begin
                if (expected_nodes.size() == 0) begin
                    $display({"%0t: unexpected node, expected none, got col %0d row %0d",
                              " value %0d end %0b"},
                             $time, m_node_col, m_node_row, m_node_value, m_run_end);
                    mismatch_count++;
                end else begin
                    want = expected_nodes.pop_front();
                    if (want.col !== m_node_col || want.row !== m_node_row ||
                        want.value !== m_node_value || want.run_end !== m_run_end) begin
                        $display({"%0t: node mismatch, expected col %0d row %0d value %0d",
                                  " end %0b, got col %0d row %0d value %0d end %0b"},
                                 $time, want.col, want.row, $signed(want.value),
                                 want.run_end, m_node_col, m_node_row, m_node_value,
                                 m_run_end);
                        mismatch_count++;
                    end
                end
            end
        end
        nodes_pending = expected_nodes.size();
    end

endmodule

/* dv/tb.sv */
// tb: stimulus and verdict for cell_to_node_average
// depends on cnavg_pkg, the block under src and node_checker, which predicts and compares
`timescale 1ns / 100ps

module tb
    import cnavg_pkg::*;
();

    localparam int VALUE_BITS    = 32;
    localparam int MAX_COLS      = 1024;
    localparam int STALL_LIMIT   = 2000;  // cycles without any request moving
    localparam int LONG_HOLD     = 300;   // one long receiver stall to back the block up
    localparam int HOLD_AT       = 60;    // node count at which that stall starts
    localparam int RANDOM_CELLS  = 160;
    localparam int SETTLE_CYCLES = 16;    // covers the pipe plus cells with no node
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index

    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]             cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [VALUE_BITS-1:0] s_cell_value;
    logic                         m_valid;
    logic                         m_ready;
    logic [COORD_W-1:0]           m_node_col;
    logic [COORD_W-1:0]           m_node_row;
    logic signed [VALUE_BITS-1:0] m_node_value;
    logic                         m_run_end;

    int mismatch_count;
    int nodes_pending;
    int nodes_taken = 0;
    int stall_cycles = 0;
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;

    // corner cases for the first grids: extremes of the value range, and in the
    // periodic grid alternating extremes so the extrapolated corners overflow and wrap
    logic signed [VALUE_BITS-1:0] edge_cells [4] = '{VAL_MAX, VAL_MIN, -1, 1};
    logic signed [VALUE_BITS-1:0] wrap_cells [9] = '{VAL_MIN, VAL_MAX, VAL_MIN,
                                                     VAL_MAX, VAL_MIN, VAL_MAX,
                                                     VAL_MIN, VAL_MAX, 0};
    logic signed [VALUE_BITS-1:0] tiny_cells [4] = '{0, 1, VAL_MAX, VAL_MIN};

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    cell_to_node_average #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_value (s_cell_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_node_col   (m_node_col),
        .m_node_row   (m_node_row),
        .m_node_value (m_node_value),
        .m_run_end    (m_run_end)
    );

    node_checker #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) node_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cell_value   (s_cell_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_node_col     (m_node_col),
        .m_node_row     (m_node_row),
        .m_node_value   (m_node_value),
        .m_run_end      (m_run_end),
        .mismatch_count (mismatch_count),
        .nodes_pending  (nodes_pending)
    );

    // mostly full-range values, with a fair share of extremes and tiny values
    function automatic logic signed [VALUE_BITS-1:0] random_cell();
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic int fit(input int d, input int top);
        return (d < 2) ? 2 : ((d > top) ? top : d);
    endfunction

    // one cell request: optional gap with valid low, then valid held until taken;
    // a zero gap keeps valid high straight into the next request
    task automatic push_cell(input logic signed [VALUE_BITS-1:0] v);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // lower valid and wait for every node still owed
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (nodes_pending != 0) @(negedge aclk);
    endtask

    // fully idle: drained, plus time for cells that owe no node to leave the pipe
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
    endtask

    // write all three registers, junk in the unused bits of the mode register,
    // and now and then a write to the empty index, which must change nothing
    task automatic grid_setup(input int c, input int r, input bit p);
        cfg_write(REG_COLS, c);
        cfg_write(REG_ROWS, r);
        cfg_write(REG_PERIODIC, ($urandom_range(0, 1023) << 1) | p);
        if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, $urandom_range(0, 2047));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // n random cells; at pause_at the sender waits until every node has come back
    task automatic run_cells(input int n, input int pause_at);
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) drain();
            push_cell(random_cell());
        end
    endtask

    // node receiver: random stalls per request, calm stretches, and one long hold
    initial begin : node_sink
        int gap;
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            if (nodes_taken == HOLD_AT && !held) begin
                gap  = LONG_HOLD;
                held = 1'b1;
            end else begin
                gap = recv_gaps ? $urandom_range(0, 9) : 0;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            nodes_taken++;
            if (nodes_taken % 40 == 0) recv_gaps = ($urandom_range(0, 2) != 0);
        end
    end

    // watchdog: ends the run when no request moves on either side for too long
    initial begin : stall_watch
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("cell_to_node_average verification failed");
        $finish;
    end

    initial begin : stimulus
        int c;
        int r;
        int frame;
        int n;
        int pause_at;
        int random_cells;
        bit p;
        random_cells = 0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_COLS;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_cell_value = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setup, 2x2 with edge rules: every node but the centre one is an edge or a corner
        foreach (edge_cells[i]) push_cell(edge_cells[i]);

        // periodic 3x3: wrapped sides and overflowing corners
        settle();
        grid_setup(3, 3, 1'b1);
        foreach (wrap_cells[i]) push_cell(wrap_cells[i]);

        // sizes below the minimum are taken as 2x2
        settle();
        grid_setup(0, 1, 1'b0);
        foreach (tiny_cells[i]) push_cell(tiny_cells[i]);

        // a larger frame first, so the long receiver hold lands while cells keep coming
        settle();
        grid_setup(16, 8, 1'b0);
        run_cells(16 * 8, -1);
        random_cells += 16 * 8;

        // random grids: mostly whole frames, some running into the next frame,
        // some cut short by the next setup
        while (random_cells < RANDOM_CELLS) begin
            c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            p = $urandom_range(0, 1);
            frame = fit(c, MAX_COLS) * fit(r, MAX_ROWS);
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, frame - 1);
            else
                n = frame * $urandom_range(1, 2);
            pause_at  = ($urandom_range(0, 5) == 0) ? n / 2 : -1;
            send_gaps = ($urandom_range(0, 3) != 0);
            settle();
            grid_setup(c, r, p);
            run_cells(n, pause_at);
            random_cells += n;
        end

        // widest grid, columns written all ones and clamped, first cells of row zero
        send_gaps = 1'b0;
        settle();
        grid_setup(2047, 2, 1'b1);
        run_cells(20, -1);

        // tallest grids, only the first rows of each
        send_gaps = 1'b1;
        settle();
        grid_setup(2, 2047, 1'b0);
        run_cells(20, -1);
        settle();
        grid_setup(3, MAX_ROWS, 1'b1);
        run_cells(21, -1);

        settle();
        if (mismatch_count == 0 && nodes_pending == 0)
            $display("cell_to_node_average verification clean");
        else
            $display("cell_to_node_average verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/cnavg_pkg.sv
src/cnavg_fifo.sv
src/cnavg_front.sv
src/cnavg_back.sv
src/cell_to_node_average.sv
dv/node_checker.sv
dv/tb.sv
